// File: rtl/dasd_pkg.sv
// dasd_pkg: shared widths, month-length table, leap rule and the
// controller/datapath command and status structs of the date add/subtract unit.
// No dependencies.
package dasd_pkg;

    localparam int MODE_W     = 1;
    localparam int YEAR_IN_W  = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int COUNT_W    = 16;
    localparam int YEAR_OUT_W = 15;

    // running year covers -181..16563, running day -65535..65566
    localparam int YEAR_W     = 16;
    localparam int DAY_ACC_W  = 18;

    // year mod 400 counter and its reciprocal-multiply initialization
    localparam int Y400_W      = 9;
    localparam int Q400_W      = 6;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP400    = 10486;   // ceil(2^22 / 400), exact for 14-bit years
    localparam int PROD_W      = 2 * YEAR_IN_W;
    localparam int REM_W       = YEAR_IN_W + 1;

    localparam logic [Y400_W-1:0] Y400_LAST = Y400_W'(399);
    localparam logic [Y400_W-1:0] CENT_1    = Y400_W'(100);
    localparam logic [Y400_W-1:0] CENT_2    = Y400_W'(200);
    localparam logic [Y400_W-1:0] CENT_3    = Y400_W'(300);

    localparam logic [MONTH_W-1:0] JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_SUB = 1'b1;

    typedef struct packed {
        logic load;       // capture a new transaction
        logic init_mul;   // estimate year / 400
        logic init_rem;   // form year mod 400
        logic step;       // normalize one month
        logic capture;    // move the finished date to the output register
    } t_cmd;

    typedef struct packed {
        logic done;       // day lies inside the running month
    } t_status;

    // Leap year from the positive flag and year mod 400.
    function automatic logic is_leap(input logic pos, input logic [Y400_W-1:0] y400);
        is_leap = pos && (y400[1:0] == 2'b00) &&
                  (y400 != CENT_1) && (y400 != CENT_2) && (y400 != CENT_3);
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2:                   len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
            default:                len = DAY_W'(31);
        endcase
        days_in = len;
    endfunction

endpackage

// File: rtl/dasd_in_if.sv
// dasd_in_if: input channel of the date add/subtract unit, valid/ready
// handshake with the starting date, day count and mode. Depends on dasd_pkg.
interface dasd_in_if;
    logic                             valid;
    logic                             ready;
    logic [dasd_pkg::MODE_W-1:0]      mode;
    logic [dasd_pkg::YEAR_IN_W-1:0]   start_year;
    logic [dasd_pkg::MONTH_W-1:0]     start_month;
    logic [dasd_pkg::DAY_W-1:0]       start_day;
    logic [dasd_pkg::COUNT_W-1:0]     day_count;

    modport source (output valid, mode, start_year, start_month, start_day, day_count,
                    input ready);
    modport sink   (input valid, mode, start_year, start_month, start_day, day_count,
                    output ready);
endinterface

// File: rtl/dasd_out_if.sv
// dasd_out_if: result channel of the date add/subtract unit, valid/ready
// handshake with the resulting date. Depends on dasd_pkg.
interface dasd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dasd_pkg::YEAR_OUT_W-1:0] result_year;
    logic [dasd_pkg::MONTH_W-1:0]          result_month;
    logic [dasd_pkg::DAY_W-1:0]            result_day;

    modport source (output valid, result_year, result_month, result_day, input ready);
    modport sink   (input valid, result_year, result_month, result_day, output ready);
endinterface

// File: rtl/dasd_ctrl.sv
// dasd_ctrl: sequencer of the date add/subtract unit; walks init, month
// normalization and result hand-off, and owns both handshakes. Depends on dasd_pkg.
module dasd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dasd_pkg::t_cmd     o_cmd,
    input  dasd_pkg::t_status  i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT_MUL,
        S_INIT_REM,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign slot_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.init_mul = (r_state == S_INIT_MUL);
        o_cmd.init_rem = (r_state == S_INIT_REM);
        o_cmd.step     = (r_state == S_RUN) && !i_status.done;
        o_cmd.capture  = (r_state == S_DONE) && slot_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_INIT_MUL;
            S_INIT_MUL: n_state = S_INIT_REM;
            S_INIT_REM: n_state = S_RUN;
            S_RUN:      if (i_status.done) n_state = S_DONE;
            S_DONE:     if (slot_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_run_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && i_status.done) |=> (r_state == S_DONE))
        else $error("normalization finished but sequencer did not advance");
    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |=> (r_state == S_RUN))
        else $error("sequencer left normalization while a month step was pending");
    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_out_valid)
        else $error("captured result not presented");
`endif

endmodule

// File: rtl/dasd_dp.sv
// dasd_dp: datapath of the date add/subtract unit; running date registers,
// year mod 400 counter, month step logic and output register. Depends on dasd_pkg.
module dasd_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dasd_pkg::t_cmd                         i_cmd,
    output dasd_pkg::t_status                      o_status,
    input  logic [dasd_pkg::MODE_W-1:0]            i_mode,
    input  logic [dasd_pkg::YEAR_IN_W-1:0]         i_start_year,
    input  logic [dasd_pkg::MONTH_W-1:0]           i_start_month,
    input  logic [dasd_pkg::DAY_W-1:0]             i_start_day,
    input  logic [dasd_pkg::COUNT_W-1:0]           i_day_count,
    output logic signed [dasd_pkg::YEAR_OUT_W-1:0] o_result_year,
    output logic [dasd_pkg::MONTH_W-1:0]           o_result_month,
    output logic [dasd_pkg::DAY_W-1:0]             o_result_day
);

    logic                                   r_mode;
    logic signed [dasd_pkg::YEAR_W-1:0]     r_year;
    logic [dasd_pkg::MONTH_W-1:0]           r_month;
    logic signed [dasd_pkg::DAY_ACC_W-1:0]  r_day;
    logic [dasd_pkg::Y400_W-1:0]            r_y400;
    logic [dasd_pkg::Q400_W-1:0]            r_q400;
    logic signed [dasd_pkg::YEAR_OUT_W-1:0] r_res_year;
    logic [dasd_pkg::MONTH_W-1:0]           r_res_month;
    logic [dasd_pkg::DAY_W-1:0]             r_res_day;

    logic [dasd_pkg::MONTH_W-1:0]           start_month_c;
    logic signed [dasd_pkg::DAY_ACC_W-1:0]  start_day_s;
    logic signed [dasd_pkg::DAY_ACC_W-1:0]  count_s;
    logic [dasd_pkg::PROD_W-1:0]            prod;
    logic [dasd_pkg::REM_W-1:0]             rem;

    logic [dasd_pkg::DAY_W-1:0]             len_cur;
    logic [dasd_pkg::DAY_W-1:0]             len_prev;
    logic                                   wrap_up, wrap_dn;
    logic [dasd_pkg::MONTH_W-1:0]           next_month, prev_month;
    logic signed [dasd_pkg::YEAR_W-1:0]     next_year, prev_year;
    logic [dasd_pkg::Y400_W-1:0]            next_y400, prev_y400, y400_inc, y400_dec;

    // clamp month into 1..12 before normalizing
    always_comb begin
        if (i_start_month < dasd_pkg::JAN) begin
            start_month_c = dasd_pkg::JAN;
        end else if (i_start_month > dasd_pkg::DEC) begin
            start_month_c = dasd_pkg::DEC;
        end else begin
            start_month_c = i_start_month;
        end
    end

    assign start_day_s = signed'(dasd_pkg::DAY_ACC_W'(i_start_day));
    assign count_s     = signed'(dasd_pkg::DAY_ACC_W'(i_day_count));

    // year / 400 by reciprocal multiply, then the remainder in the next cycle
    assign prod = r_year[dasd_pkg::YEAR_IN_W-1:0] *
                  dasd_pkg::YEAR_IN_W'(dasd_pkg::RECIP400);
    assign rem  = dasd_pkg::REM_W'(r_year[dasd_pkg::YEAR_IN_W-1:0]) -
                  dasd_pkg::REM_W'(r_q400 * dasd_pkg::Y400_W'(400));

    // forward and backward neighbor months
    assign y400_inc   = (r_y400 == dasd_pkg::Y400_LAST) ? '0 : r_y400 + 1'b1;
    assign y400_dec   = (r_y400 == '0) ? dasd_pkg::Y400_LAST : r_y400 - 1'b1;
    assign wrap_up    = (r_month == dasd_pkg::DEC);
    assign wrap_dn    = (r_month == dasd_pkg::JAN);
    assign next_month = wrap_up ? dasd_pkg::JAN : r_month + 1'b1;
    assign prev_month = wrap_dn ? dasd_pkg::DEC : r_month - 1'b1;
    assign next_year  = wrap_up ? r_year + signed'(dasd_pkg::YEAR_W'(1)) : r_year;
    assign prev_year  = wrap_dn ? r_year - signed'(dasd_pkg::YEAR_W'(1)) : r_year;
    assign next_y400  = wrap_up ? y400_inc : r_y400;
    assign prev_y400  = wrap_dn ? y400_dec : r_y400;

    assign len_cur  = dasd_pkg::days_in(r_month,
                                        dasd_pkg::is_leap(r_year > 0, r_y400));
    assign len_prev = dasd_pkg::days_in(prev_month,
                                        dasd_pkg::is_leap(prev_year > 0, prev_y400));

    always_comb begin
        if (r_mode == dasd_pkg::MODE_ADD) begin
            o_status.done = (r_day <= signed'(dasd_pkg::DAY_ACC_W'(len_cur)));
        end else begin
            o_status.done = (r_day > 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode[0];
            r_year  <= signed'(dasd_pkg::YEAR_W'(i_start_year));
            r_month <= start_month_c;
            r_day   <= (i_mode[0] == dasd_pkg::MODE_ADD) ? start_day_s + count_s
                                                         : start_day_s - count_s;
        end
        if (i_cmd.init_mul) begin
            r_q400 <= prod[dasd_pkg::PROD_W-1:dasd_pkg::RECIP_SHIFT];
        end
        if (i_cmd.init_rem) begin
            r_y400 <= rem[dasd_pkg::Y400_W-1:0];
        end
        if (i_cmd.step) begin
            if (r_mode == dasd_pkg::MODE_ADD) begin
                r_day   <= r_day - signed'(dasd_pkg::DAY_ACC_W'(len_cur));
                r_month <= next_month;
                r_year  <= next_year;
                r_y400  <= next_y400;
            end else begin
                r_day   <= r_day + signed'(dasd_pkg::DAY_ACC_W'(len_prev));
                r_month <= prev_month;
                r_year  <= prev_year;
                r_y400  <= prev_y400;
            end
        end
        if (i_cmd.capture) begin
            r_res_year  <= r_year[dasd_pkg::YEAR_OUT_W-1:0];
            r_res_month <= r_month;
            r_res_day   <= r_day[dasd_pkg::DAY_W-1:0];
        end
    end

    assign o_result_year  = r_res_year;
    assign o_result_month = r_res_month;
    assign o_result_day   = r_res_day;

`ifndef ASSERT_OFF
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_month >= dasd_pkg::JAN && r_month <= dasd_pkg::DEC))
        else $error("running month left 1..12");
    a_add_day_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_mode == dasd_pkg::MODE_ADD) |=> (r_day > 0))
        else $error("forward step drove the day to zero or below");
    a_y400_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.init_rem |=> (r_y400 <= dasd_pkg::Y400_LAST))
        else $error("year mod 400 out of range after init");
`endif

endmodule

// File: rtl/date_add_subtract_days.sv
// date_add_subtract_days: top level of the Gregorian date add/subtract unit.
// Depends on dasd_pkg, dasd_in_if, dasd_out_if, dasd_ctrl and dasd_dp.
//
// Usage:
//   i_in  (sink):   one transaction carries mode, start_year, start_month,
//                   start_day and day_count; accepted when valid and ready.
//   o_out (source): one transaction per input with result_year (two's
//                   complement), result_month and result_day.
//   Sequence: accept in idle, form year mod 400 in the multiply state and
//   then the subtract state (one multiply, one subtract), step one month per
//   pass through the run state until the day settles, then hand the result
//   off in the done state; the month-stepping loop dominates for large
//   counts. One transaction is in work at a time; the next is
//   accepted right after the result moves to the output register, even
//   while that result still waits.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
//   any pending result. When the receiver stalls, the finished result holds
//   in the output register and the next computed result waits in the
//   datapath until the register frees up.
module date_add_subtract_days (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dasd_in_if.sink    i_in,
    dasd_out_if.source o_out
);

    dasd_pkg::t_cmd    cmd;
    dasd_pkg::t_status status;

    // sequencer: handshakes and per-cycle commands
    dasd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // datapath: running date, leap counter, output register
    dasd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_in.mode),
        .i_start_year   (i_in.start_year),
        .i_start_month  (i_in.start_month),
        .i_start_day    (i_in.start_day),
        .i_day_count    (i_in.day_count),
        .o_result_year  (o_out.result_year),
        .o_result_month (o_out.result_month),
        .o_result_day   (o_out.result_day)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second transaction accepted while one is in work");
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load == (i_in.valid && i_in.ready))
        else $error("datapath load does not match input acceptance");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid &&
            $stable(o_out.result_year) && $stable(o_out.result_month) &&
            $stable(o_out.result_day)))
        else $error("stalled result changed or dropped");
`endif

endmodule

// File: bench/date_shift_checker.sv
// date_shift_checker: watches both channels of date_add_subtract_days, computes
// the date each input transaction should give and compares it with the results.
// Depends on dasd_pkg.
module date_shift_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic [dasd_pkg::MODE_W-1:0]            i_mode,
    input  logic [dasd_pkg::YEAR_IN_W-1:0]         i_start_year,
    input  logic [dasd_pkg::MONTH_W-1:0]           i_start_month,
    input  logic [dasd_pkg::DAY_W-1:0]             i_start_day,
    input  logic [dasd_pkg::COUNT_W-1:0]           i_day_count,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic signed [dasd_pkg::YEAR_OUT_W-1:0] i_result_year,
    input  logic [dasd_pkg::MONTH_W-1:0]           i_result_month,
    input  logic [dasd_pkg::DAY_W-1:0]             i_result_day,
    output int                                     o_fail_count,
    output int                                     o_open_count
);

    localparam int SHOWN_FAILURES = 10;

    typedef struct packed {
        logic [dasd_pkg::YEAR_OUT_W-1:0] year;
        logic [dasd_pkg::MONTH_W-1:0]    month;
        logic [dasd_pkg::DAY_W-1:0]      day;
    } t_cal_date;

    t_cal_date expected_dates[$];
    int        fail_cnt;

    assign o_fail_count = fail_cnt;

    // Gregorian month length; years of zero or below are never leap.
    function automatic int month_length(input int yr, input int mon);
        bit leap;
        leap = (yr > 0) && (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0));
        case (mon)
            int'(dasd_pkg::FEB): return leap ? 29 : 28;
            4, 6, 9, 11:         return 30;
            default:             return 31;
        endcase
    endfunction

    // Move the date by the day count, one month at a time.
    function automatic t_cal_date shift_date(input logic [dasd_pkg::MODE_W-1:0] mode,
                                             input logic [dasd_pkg::YEAR_IN_W-1:0] y_in,
                                             input logic [dasd_pkg::MONTH_W-1:0] m_in,
                                             input logic [dasd_pkg::DAY_W-1:0] d_in,
                                             input logic [dasd_pkg::COUNT_W-1:0] cnt);
        int        yr;
        int        mon;
        int        dy;
        t_cal_date r;
        yr  = int'(y_in);
        mon = int'(m_in);
        dy  = int'(d_in);
        // clamp an out-of-range month before stepping
        if (mon < int'(dasd_pkg::JAN))
            mon = int'(dasd_pkg::JAN);
        if (mon > int'(dasd_pkg::DEC))
            mon = int'(dasd_pkg::DEC);
        if (mode == dasd_pkg::MODE_ADD) begin
            dy += int'(cnt);
            while (dy > month_length(yr, mon)) begin
                dy -= month_length(yr, mon);
                mon++;
                if (mon > int'(dasd_pkg::DEC)) begin
                    mon = int'(dasd_pkg::JAN);
                    yr++;
                end
            end
        end else begin
            dy -= int'(cnt);
            while (dy <= 0) begin
                mon--;
                if (mon < int'(dasd_pkg::JAN)) begin
                    mon = int'(dasd_pkg::DEC);
                    yr--;
                end
                dy += month_length(yr, mon);
            end
        end
        r.year  = yr[dasd_pkg::YEAR_OUT_W-1:0];
        r.month = mon[dasd_pkg::MONTH_W-1:0];
        r.day   = dy[dasd_pkg::DAY_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_cal_date want;
        t_cal_date got;
        if (!i_rst_n) begin
            expected_dates.delete();
            fail_cnt     <= 0;
            o_open_count <= 0;
        end else begin
            // retire the oldest expectation before queueing a new one
            if (i_out_valid && i_out_ready) begin
                got = '{year: i_result_year, month: i_result_month, day: i_result_day};
                if (expected_dates.size() == 0) begin
                    if (fail_cnt < SHOWN_FAILURES)
                        $display("%0t: result %0d-%0d-%0d with no transaction pending",
                                 $realtime, $signed(got.year), got.month, got.day);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    want = expected_dates.pop_front();
                    if (got.year != want.year || got.month != want.month ||
                        got.day != want.day) begin
                        if (fail_cnt < SHOWN_FAILURES)
                            $display("%0t: date mismatch, expected %0d-%0d-%0d got %0d-%0d-%0d",
                                     $realtime, $signed(want.year), want.month, want.day,
                                     $signed(got.year), got.month, got.day);
                        fail_cnt <= fail_cnt + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_dates.push_back(shift_date(i_mode, i_start_year, i_start_month,
                                                    i_start_day, i_day_count));
            o_open_count <= expected_dates.size();
        end
    end

endmodule

// File: bench/tb.sv
// tb: stimulus and verdict for date_add_subtract_days; a directed set of dates
// followed by random transactions with random idling, checked by date_shift_checker.
// Depends on dasd_pkg, dasd_in_if, dasd_out_if, date_shift_checker and the block.
module tb;

    localparam int RANDOM_ITEMS = 240;
    localparam int QUIET_ITEMS  = 40;     // tail of the run without idling
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 2200;   // extra wait at the end, after the last result is back
    localparam int IDLE_LIMIT   = 40000;  // cycles with no transaction before giving up

    logic i_clk = 1'b0;
    logic i_rst_n;

    // Knobs that steer the sender and the receiver.
    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    int fail_count;
    int open_count;
    int idle_cycles = 0;

    dasd_in_if  in_ch ();
    dasd_out_if out_ch ();

    date_add_subtract_days dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    date_shift_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_ch.valid),
        .i_in_ready     (in_ch.ready),
        .i_mode         (in_ch.mode),
        .i_start_year   (in_ch.start_year),
        .i_start_month  (in_ch.start_month),
        .i_start_day    (in_ch.start_day),
        .i_day_count    (in_ch.day_count),
        .i_out_valid    (out_ch.valid),
        .i_out_ready    (out_ch.ready),
        .i_result_year  (out_ch.result_year),
        .i_result_month (out_ch.result_month),
        .i_result_day   (out_ch.result_day),
        .o_fail_count   (fail_count),
        .o_open_count   (open_count)
    );

    // 20-unit clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: count cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: ready by default, random short stalls, and one long hold-off
    // when the stimulus asks for it. Each pass through the loop drives ready once.
    initial begin : result_side
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                // hold off long enough for the block to fill and stall its input
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (stall_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one transaction, after an optional idle burst, and hold it until
    // accepted. Valid is left high on return so back-to-back items need no
    // second assignment in the same step.
    task automatic send_shift(input logic [dasd_pkg::MODE_W-1:0] mode,
                              input logic [dasd_pkg::YEAR_IN_W-1:0] yr,
                              input logic [dasd_pkg::MONTH_W-1:0] mon,
                              input logic [dasd_pkg::DAY_W-1:0] dy,
                              input logic [dasd_pkg::COUNT_W-1:0] cnt);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.start_year  <= yr;
        in_ch.start_month <= mon;
        in_ch.start_day   <= dy;
        in_ch.day_count   <= cnt;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
    endtask

    // Random transaction: mostly valid dates and short counts, with a share of
    // full-range counts, early years, oversized years and malformed months/days.
    task automatic send_random_shift();
        logic [dasd_pkg::MODE_W-1:0]    mode;
        logic [dasd_pkg::YEAR_IN_W-1:0] yr;
        logic [dasd_pkg::MONTH_W-1:0]   mon;
        logic [dasd_pkg::DAY_W-1:0]     dy;
        logic [dasd_pkg::COUNT_W-1:0]   cnt;
        int                             pick;
        mode = $urandom_range(0, 1) ? dasd_pkg::MODE_SUB : dasd_pkg::MODE_ADD;
        pick = $urandom_range(0, 19);
        if (pick < 17)
            yr = dasd_pkg::YEAR_IN_W'($urandom_range(1, 9999));
        else if (pick < 18)
            yr = dasd_pkg::YEAR_IN_W'($urandom_range(1, 3));
        else
            yr = dasd_pkg::YEAR_IN_W'($urandom);
        mon = ($urandom_range(0, 9) == 0) ? dasd_pkg::MONTH_W'($urandom) :
                                            dasd_pkg::MONTH_W'($urandom_range(1, 12));
        pick = $urandom_range(0, 9);
        if (pick < 8)
            dy = dasd_pkg::DAY_W'($urandom_range(1, 28));
        else if (pick < 9)
            dy = dasd_pkg::DAY_W'($urandom_range(29, 31));
        else
            dy = dasd_pkg::DAY_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            cnt = dasd_pkg::COUNT_W'($urandom_range(0, 60));
        else if (pick < 8)
            cnt = dasd_pkg::COUNT_W'($urandom_range(0, 2000));
        else
            cnt = dasd_pkg::COUNT_W'($urandom);
        send_shift(mode, yr, mon, dy, cnt);
    endtask

    initial begin : stimulus
        // Drive every input to a known value while reset is held, then release reset.
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.mode        <= dasd_pkg::MODE_ADD;
        in_ch.start_year  <= '0;
        in_ch.start_month <= '0;
        in_ch.start_day   <= '0;
        in_ch.day_count   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: count extremes, leap rules, wraps and malformed dates.
        send_shift(dasd_pkg::MODE_ADD, 14'd2024, 4'd1,  5'd1,  16'd0);
        send_shift(dasd_pkg::MODE_SUB, 14'd2024, 4'd1,  5'd1,  16'd0);
        send_shift(dasd_pkg::MODE_ADD, 14'd2024, 4'd2,  5'd28, 16'd1);     // leap by 4
        send_shift(dasd_pkg::MODE_ADD, 14'd1900, 4'd2,  5'd28, 16'd1);     // century
        send_shift(dasd_pkg::MODE_ADD, 14'd2000, 4'd2,  5'd28, 16'd1);     // leap by 400
        send_shift(dasd_pkg::MODE_SUB, 14'd2100, 4'd3,  5'd1,  16'd1);
        send_shift(dasd_pkg::MODE_ADD, 14'd1999, 4'd12, 5'd31, 16'd1);     // year forward
        send_shift(dasd_pkg::MODE_SUB, 14'd2000, 4'd1,  5'd1,  16'd1);     // year back
        send_shift(dasd_pkg::MODE_ADD, 14'd2023, 4'd0,  5'd15, 16'd20);    // month low
        send_shift(dasd_pkg::MODE_SUB, 14'd2023, 4'd13, 5'd15, 16'd20);    // month high
        send_shift(dasd_pkg::MODE_ADD, 14'd2023, 4'd15, 5'd31, 16'd0);
        send_shift(dasd_pkg::MODE_ADD, 14'd2023, 4'd5,  5'd0,  16'd0);     // day zero stays
        send_shift(dasd_pkg::MODE_SUB, 14'd2023, 4'd5,  5'd0,  16'd0);     // day zero back
        send_shift(dasd_pkg::MODE_ADD, 14'd2023, 4'd2,  5'd31, 16'd0);     // past month end
        send_shift(dasd_pkg::MODE_SUB, 14'd2023, 4'd2,  5'd31, 16'd0);
        send_shift(dasd_pkg::MODE_SUB, 14'd1,    4'd1,  5'd1,  16'd1);     // into year zero
        send_shift(dasd_pkg::MODE_SUB, 14'd1,    4'd3,  5'd1,  16'd800);   // year zero
        send_shift(dasd_pkg::MODE_SUB, 14'd1,    4'd1,  5'd1,  16'hFFFF);  // deep negative
        send_shift(dasd_pkg::MODE_ADD, 14'd9999, 4'd12, 5'd31, 16'hFFFF);
        send_shift(dasd_pkg::MODE_SUB, 14'd9999, 4'd12, 5'd31, 16'hFFFF);
        send_shift(dasd_pkg::MODE_ADD, 14'h3FFF, 4'd12, 5'd31, 16'hFFFF);  // year wraps
        send_shift(dasd_pkg::MODE_SUB, 14'h3FFF, 4'd15, 5'd31, 16'h8000);
        send_shift(dasd_pkg::MODE_ADD, 14'h2AAA, 4'd10, 5'd21, 16'h5555);
        send_shift(dasd_pkg::MODE_SUB, 14'h1555, 4'd5,  5'd10, 16'hAAAA);

        // Random part with a long hold-off and a full drain in the middle.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 90) begin
                // Hold the receiver off and keep offering short transactions
                // back to back so the block fills and stalls its input.
                gaps_on  = 1'b0;
                hold_req = 1'b1;
                repeat (8)
                    send_shift($urandom_range(0, 1) ? dasd_pkg::MODE_SUB
                                                    : dasd_pkg::MODE_ADD,
                               dasd_pkg::YEAR_IN_W'($urandom_range(1, 9999)),
                               dasd_pkg::MONTH_W'($urandom_range(1, 12)),
                               dasd_pkg::DAY_W'($urandom_range(1, 28)),
                               dasd_pkg::COUNT_W'($urandom_range(0, 40)));
                gaps_on = 1'b1;
            end
            if (k == 180) begin
                // Pause the sender until every result is back.
                in_ch.valid <= 1'b0;
                do
                    @(posedge i_clk);
                while (open_count != 0);
            end
            if (k == RANDOM_ITEMS - QUIET_ITEMS) begin
                // Finish at full rate on both sides.
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end
            send_random_shift();
        end

        // Drop valid, wait for the last results, then allow the latency tail.
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (open_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && open_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/dasd_pkg.sv
rtl/dasd_in_if.sv
rtl/dasd_out_if.sv
rtl/dasd_ctrl.sv
rtl/dasd_dp.sv
rtl/date_add_subtract_days.sv
bench/date_shift_checker.sv
bench/tb.sv
